// ===== rtl/nsp_pkg.sv =====
// Shared types, constants and tables for the neutrino survival probability core.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none

package nsp_pkg;

  localparam int PHASE_FRAC_BITS_DEF = 24;
  localparam int SINE_STAGES_DEF     = 18;

  // round(1.267 / pi * 2^32)
  localparam logic [30:0] PHASE_CONST  = 31'd1732154408;
  localparam logic [15:0] S13_NORMAL   = 16'd1468;
  localparam logic [15:0] S13_INVERTED = 16'd1483;
  localparam logic [16:0] ONE_Q16      = 17'd65536;

  localparam logic [19:0] RST_BASELINE = 20'd52500;
  localparam logic [30:0] RST_DM21     = 31'd5078154;
  localparam logic [31:0] RST_DM31     = 32'd0;
  localparam logic [15:0] RST_S12      = 16'd20316;
  localparam logic [15:0] RST_S13      = 16'd1468;

  // cycles the item side waits after a register write
  localparam logic [1:0] CFG_SETTLE = 2'd3;

  localparam int E_W   = 24;  // energy / divisor width
  localparam int XY_W  = 33;  // CORDIC datapath width
  localparam int UW    = 25;  // |x|>>8, |y|>>8
  localparam int DW    = 51;  // x^2 + y^2
  localparam int RW    = 68;  // ratio remainder
  localparam int QB    = 17;  // sin^2 quotient bits

  typedef enum logic [2:0] {
    CFG_BASELINE = 3'd0,
    CFG_DM21     = 3'd1,
    CFG_DM31     = 3'd2,
    CFG_S12      = 3'd3,
    CFG_S13      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [E_W-1:0] rem;
    logic [E_W-1:0] div;
  } div_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [XY_W-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [DW-1:0] den;
  } rat_t;

  // atan(2^-i) in Q0.32 turns
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

endpackage

`default_nettype wire

// ===== rtl/neutrino_survival_probability_core.sv =====
// Top level of the three-flavor antineutrino survival probability core.
// Depends on nsp_pkg and nsp_lane (which uses the division, CORDIC and ratio cells).
`default_nettype none

// Fully pipelined: one energy beat may enter every cycle and one probability
// beat leaves per energy beat, in order. Each beat passes through the
// bit-per-cell phase divider (PHASE_FRAC_BITS + 31 cells), the CORDIC row
// (SINE_STAGES cells) and the 17-cell sin^2 divider, run as three lanes in
// parallel for dm21, dm31 and dm32. When the output stalls the whole row
// holds, but the input stage still takes one beat into an empty slot. The
// input is held off while a register write is offered, and after each
// register write and after reset until the CFG_SETTLE countdown runs out,
// while the baseline/splitting product pipeline settles. Register writes are
// always accepted; indexes above four are ignored.

module neutrino_survival_probability_core #(
  parameter int PHASE_FRAC_BITS = nsp_pkg::PHASE_FRAC_BITS_DEF,
  parameter int SINE_STAGES     = nsp_pkg::SINE_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_energy_mev,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] out_probability,
  output logic        out_zero_energy,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int XW       = PHASE_FRAC_BITS + 31;
  localparam int LANE_LAT = XW + SINE_STAGES + 21;
  localparam int VL       = LANE_LAT + 2;

  // ---------------- configuration registers ----------------
  logic [19:0] baseline_r;
  logic [30:0] dm21_r;
  logic [31:0] dm31_r;
  logic [15:0] s12_r;
  logic [15:0] s13cfg_r;
  logic [1:0]  hold_r;
  logic        cfg_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r <= nsp_pkg::RST_BASELINE;
      dm21_r     <= nsp_pkg::RST_DM21;
      dm31_r     <= nsp_pkg::RST_DM31;
      s12_r      <= nsp_pkg::RST_S12;
      s13cfg_r   <= nsp_pkg::RST_S13;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        nsp_pkg::CFG_BASELINE: baseline_r <= cfg_data[19:0];
        nsp_pkg::CFG_DM21:     dm21_r     <= cfg_data[30:0];
        nsp_pkg::CFG_DM31:     dm31_r     <= cfg_data;
        nsp_pkg::CFG_S12:      s12_r      <= cfg_data[15:0];
        nsp_pkg::CFG_S13:      s13cfg_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input holdoff while the product pipeline below catches up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= nsp_pkg::CFG_SETTLE;
    end else if (cfg_acc) begin
      hold_r <= nsp_pkg::CFG_SETTLE;
    end else if (hold_r != '0) begin
      hold_r <= hold_r - 2'd1;
    end
  end

  // ---------------- config-derived products (free running) ----------------
  logic signed [32:0] d31;
  logic signed [33:0] d32;
  logic [32:0]        m31w;
  logic [33:0]        m32w;
  logic [15:0]        s13_nxt;
  logic [31:0]        mag_r  [3];
  logic [15:0]        s13_r;
  logic [62:0]        prod_r [3];
  logic [51:0]        pl_r   [3];
  logic [50:0]        ph_r   [3];
  logic [82:0]        sum    [3];
  logic [XW-1:0]      numer_r [3];

  assign d31  = $signed({dm31_r[31], dm31_r});
  assign d32  = $signed({d31[32], d31}) - $signed({3'b0, dm21_r});
  assign m31w = d31[32] ? 33'(-d31) : 33'(d31);
  assign m32w = d32[33] ? 34'(-d32) : 34'(d32);

  always_comb begin
    if (d31 > 33'sd0) begin
      s13_nxt = nsp_pkg::S13_NORMAL;
    end else if (d31 < 33'sd0) begin
      s13_nxt = nsp_pkg::S13_INVERTED;
    end else begin
      s13_nxt = s13cfg_r;
    end
  end

  always_ff @(posedge clk) begin
    mag_r[0] <= {1'b0, dm21_r};
    mag_r[1] <= m31w[31:0];
    mag_r[2] <= m32w[31:0];
    s13_r    <= s13_nxt;
  end

  for (genvar k = 0; k < 3; k++) begin : g_numer
    assign sum[k] = {ph_r[k], 32'b0} + {31'b0, pl_r[k]};
    always_ff @(posedge clk) begin
      prod_r[k]  <= mag_r[k] * nsp_pkg::PHASE_CONST;
      pl_r[k]    <= prod_r[k][31:0] * baseline_r;
      ph_r[k]    <= prod_r[k][62:32] * baseline_r;
      numer_r[k] <= sum[k][82 -: XW];
    end
  end

  // mixing coefficients
  logic [16:0] c13;
  logic [16:0] c12;
  logic [33:0] p13;
  logic [33:0] p13sq;
  logic [33:0] p12;
  logic [33:0] pb;
  logic [16:0] a1_r;
  logic [16:0] b1_r;
  logic [16:0] b2_r;
  logic [16:0] b3_r;

  assign c13   = nsp_pkg::ONE_Q16 - {1'b0, s13_r};
  assign c12   = nsp_pkg::ONE_Q16 - {1'b0, s12_r};
  assign p13   = {1'b0, s13_r} * c13;
  assign p13sq = c13 * c13;
  assign p12   = {1'b0, s12_r} * c12;
  assign pb    = b1_r * b2_r;

  always_ff @(posedge clk) begin
    a1_r <= p13[30:14];
    b1_r <= p13sq[32:16];
    b2_r <= p12[30:14];
    b3_r <= pb[32:16];
  end

  // ---------------- item pipeline ----------------
  logic        adv;
  logic        ld0;
  logic        in_acc;
  logic        v0_r;
  logic [23:0] e0_r;
  logic        vld_r [VL];
  logic        zf_r  [VL];
  logic        out_valid_r;
  logic [16:0] prob_r;
  logic        zero_r;

  assign adv      = !out_valid_r || out_ready;
  assign ld0      = adv || !v0_r;
  assign in_ready = ld0 && (hold_r == '0) && !cfg_valid;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (ld0) begin
      v0_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      e0_r <= in_energy_mev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VL; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= v0_r;
      for (int i = 1; i < VL; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[VL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zf_r[0] <= (e0_r == '0);
      for (int i = 1; i < VL; i++) begin
        zf_r[i] <= zf_r[i-1];
      end
    end
  end

  logic [16:0] sin2 [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    nsp_lane #(.PFB(PHASE_FRAC_BITS), .SS(SINE_STAGES)) u_lane (
      .clk   (clk),
      .en    (adv),
      .energy(e0_r),
      .numer (numer_r[k]),
      .sin2  (sin2[k])
    );
  end

  // combine: lane 0 is dm21, lane 1 dm31, lane 2 dm32
  logic [33:0]        m1;
  logic [33:0]        m2;
  logic [33:0]        a2sum;
  logic [17:0]        a2_r;
  logic [16:0]        s21_r;
  logic [34:0]        t1_r;
  logic [33:0]        t2_r;
  logic signed [36:0] p;
  logic [19:0]        pq;
  logic [16:0]        prob_nxt;

  assign m1    = c12 * sin2[1];
  assign m2    = {1'b0, s12_r} * sin2[2];
  assign a2sum = m1 + m2;

  assign p  = 37'sh1_0000_0000 - $signed({2'b0, t1_r}) - $signed({3'b0, t2_r});
  assign pq = p[35:16];

  always_comb begin
    if (zf_r[VL-1]) begin
      prob_nxt = nsp_pkg::ONE_Q16;
    end else if (p[36]) begin
      prob_nxt = '0;
    end else if (pq > {3'b0, nsp_pkg::ONE_Q16}) begin
      prob_nxt = nsp_pkg::ONE_Q16;
    end else begin
      prob_nxt = pq[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2_r   <= a2sum[33:16];
      s21_r  <= sin2[0];
      t1_r   <= a1_r * a2_r;
      t2_r   <= b3_r * s21_r;
      prob_r <= prob_nxt;
      zero_r <= zf_r[VL-1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_probability = prob_r;
  assign out_zero_energy = zero_r;

`ifndef SYNTHESIS
  a_no_accept_in_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (hold_r == '0 && !cfg_valid))
    else $error("energy beat accepted during register settle window");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !in_ready)
    else $error("input ready right after a register write");

  a_zero_gives_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_energy) |-> (out_probability == nsp_pkg::ONE_Q16))
    else $error("zero energy beat without probability one");

  a_prob_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_probability <= nsp_pkg::ONE_Q16))
    else $error("probability above one");
`endif

endmodule

`default_nettype wire

// ===== rtl/nsp_div_cell.sv =====
// One restoring-division cell: takes one numerator bit, yields one quotient bit.
// Depends on nsp_pkg.
`default_nettype none

module nsp_div_cell #(
  parameter int QW = nsp_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  logic          num_bit,
  input  nsp_pkg::div_t d_in,
  input  logic [QW-1:0] q_in,
  output nsp_pkg::div_t d_out,
  output logic [QW-1:0] q_out
);

  logic [nsp_pkg::E_W:0] trial;
  logic [nsp_pkg::E_W:0] diff;
  logic                  take;
  nsp_pkg::div_t         d_r;
  logic [QW-1:0]         q_r;

  assign trial = {d_in.rem, num_bit};
  assign take  = trial >= {1'b0, d_in.div};
  assign diff  = trial - {1'b0, d_in.div};

  always_ff @(posedge clk) begin
    if (en) begin
      d_r.rem <= take ? diff[nsp_pkg::E_W-1:0] : trial[nsp_pkg::E_W-1:0];
      d_r.div <= d_in.div;
      q_r     <= {q_in[QW-2:0], take};
    end
  end

  assign d_out = d_r;
  assign q_out = q_r;

endmodule

`default_nettype wire

// ===== rtl/nsp_cordic_cell.sv =====
// One CORDIC rotation cell with its own atan constant.
// Depends on nsp_pkg.
`default_nettype none

module nsp_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             en,
  input  nsp_pkg::cordic_t c_in,
  output nsp_pkg::cordic_t c_out
);

  logic signed [nsp_pkg::XY_W-1:0] dx;
  logic signed [nsp_pkg::XY_W-1:0] dy;
  logic signed [nsp_pkg::XY_W-1:0] at;
  nsp_pkg::cordic_t                c_r;

  assign dx = c_in.y >>> IDX;
  assign dy = c_in.x >>> IDX;
  assign at = $signed({1'b0, nsp_pkg::ATAN_TURNS[IDX]});

  always_ff @(posedge clk) begin
    if (en) begin
      if (!c_in.z[nsp_pkg::XY_W-1]) begin
        c_r.x <= c_in.x - dx;
        c_r.y <= c_in.y + dy;
        c_r.z <= c_in.z - at;
      end else begin
        c_r.x <= c_in.x + dx;
        c_r.y <= c_in.y - dy;
        c_r.z <= c_in.z + at;
      end
    end
  end

  assign c_out = c_r;

endmodule

`default_nettype wire

// ===== rtl/nsp_ratio_cell.sv =====
// One cell of the y^2/(x^2+y^2) divider: settles quotient bit K.
// Depends on nsp_pkg.
`default_nettype none

module nsp_ratio_cell #(
  parameter int K = 0
) (
  input  logic                   clk,
  input  logic                   en,
  input  nsp_pkg::rat_t          r_in,
  input  logic [nsp_pkg::QB-1:0] q_in,
  output nsp_pkg::rat_t          r_out,
  output logic [nsp_pkg::QB-1:0] q_out
);

  logic [nsp_pkg::RW-1:0] sh;
  logic                   take;
  logic [nsp_pkg::QB-1:0] q_nxt;
  nsp_pkg::rat_t          r_r;
  logic [nsp_pkg::QB-1:0] q_r;

  assign sh   = {{(nsp_pkg::RW-nsp_pkg::DW){1'b0}}, r_in.den} << K;
  assign take = r_in.rem >= sh;

  always_comb begin
    q_nxt    = q_in;
    q_nxt[K] = take;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r.rem <= take ? (r_in.rem - sh) : r_in.rem;
      r_r.den <= r_in.den;
      q_r     <= q_nxt;
    end
  end

  assign r_out = r_r;
  assign q_out = q_r;

endmodule

`default_nettype wire

// ===== rtl/nsp_lane.sv =====
// One mass-splitting lane: phase division, fold, CORDIC, sin^2 ratio.
// Depends on nsp_pkg, nsp_div_cell, nsp_cordic_cell, nsp_ratio_cell.
`default_nettype none

module nsp_lane #(
  parameter int PFB = nsp_pkg::PHASE_FRAC_BITS_DEF,
  parameter int SS  = nsp_pkg::SINE_STAGES_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [nsp_pkg::E_W-1:0] energy,
  input  logic [PFB+30:0]         numer,
  output logic [nsp_pkg::QB-1:0]  sin2
);

  localparam int XW = PFB + 31;

  nsp_pkg::div_t          dch [XW+1];
  logic [PFB-1:0]         qch [XW+1];
  nsp_pkg::cordic_t       cch [SS+1];
  nsp_pkg::rat_t          rch [nsp_pkg::QB+1];
  logic [nsp_pkg::QB-1:0] rq  [nsp_pkg::QB+1];

  logic [XW-1:0]           aw;
  logic [31:0]             a_raw;
  logic [31:0]             a_nxt;
  logic [31:0]             a_r;
  logic [nsp_pkg::XY_W-1:0] ax;
  logic [nsp_pkg::XY_W-1:0] ay;
  logic [nsp_pkg::UW-1:0]  ux_r;
  logic [nsp_pkg::UW-1:0]  uy_r;
  logic [2*nsp_pkg::UW-1:0] uxx_r;
  logic [2*nsp_pkg::UW-1:0] uyy_r;
  logic [nsp_pkg::DW-1:0]  den_r;
  logic [nsp_pkg::RW-1:0]  num_r;

  // phase = numer / energy, one quotient bit per cell, low PFB bits kept
  assign dch[0] = '{rem: '0, div: energy};
  assign qch[0] = '0;

  for (genvar g = 0; g < XW; g++) begin : g_div
    nsp_div_cell #(.QW(PFB)) u_cell (
      .clk    (clk),
      .en     (en),
      .num_bit(numer[XW-1-g]),
      .d_in   (dch[g]),
      .q_in   (qch[g]),
      .d_out  (dch[g+1]),
      .q_out  (qch[g+1])
    );
  end

  // half turns to Q0.32 turns, folded into the first quarter turn
  assign aw    = {qch[XW], 31'b0} >> PFB;
  assign a_raw = {1'b0, aw[30:0]};
  assign a_nxt = (a_raw > 32'h4000_0000) ? (32'h8000_0000 - a_raw) : a_raw;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
    end
  end

  assign cch[0] = '{x: 33'sh0_4000_0000, y: '0, z: $signed({1'b0, a_r})};

  for (genvar g = 0; g < SS; g++) begin : g_cordic
    nsp_cordic_cell #(.IDX(g)) u_cell (
      .clk  (clk),
      .en   (en),
      .c_in (cch[g]),
      .c_out(cch[g+1])
    );
  end

  assign ax = cch[SS].x[nsp_pkg::XY_W-1] ? nsp_pkg::XY_W'(-cch[SS].x) : cch[SS].x;
  assign ay = cch[SS].y[nsp_pkg::XY_W-1] ? nsp_pkg::XY_W'(-cch[SS].y) : cch[SS].y;

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r  <= ax[nsp_pkg::XY_W-1:8];
      uy_r  <= ay[nsp_pkg::XY_W-1:8];
      uxx_r <= ux_r * ux_r;
      uyy_r <= uy_r * uy_r;
      den_r <= {1'b0, uxx_r} + {1'b0, uyy_r};
      num_r <= {{(nsp_pkg::RW-2*nsp_pkg::UW-16){1'b0}}, uyy_r, 16'b0};
    end
  end

  // sin^2 = y^2 * 2^16 / (x^2 + y^2), quotient MSB first
  assign rch[0] = '{rem: num_r, den: den_r};
  assign rq[0]  = '0;

  for (genvar g = 0; g < nsp_pkg::QB; g++) begin : g_ratio
    nsp_ratio_cell #(.K(nsp_pkg::QB-1-g)) u_cell (
      .clk  (clk),
      .en   (en),
      .r_in (rch[g]),
      .q_in (rq[g]),
      .r_out(rch[g+1]),
      .q_out(rq[g+1])
    );
  end

  assign sin2 = (rch[nsp_pkg::QB].den == '0) ? '0 : rq[nsp_pkg::QB];

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for neutrino_survival_probability_core.
// Needs nsp_pkg and the core RTL. It predicts each probability beat and checks the beats in order.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PFB = nsp_pkg::PHASE_FRAC_BITS_DEF;
  localparam int NSTAGE = nsp_pkg::SINE_STAGES_DEF;
  localparam logic [2:0] CFG_IDX_SPARE_LO = 3'd5;  // writes here are dropped
  localparam logic [2:0] CFG_IDX_SPARE_HI = 3'd7;
  localparam int PIPE_DRAIN = 120;

  typedef struct {
    logic [19:0] baseline;
    logic [30:0] dm21;
    logic [31:0] dm31;
    logic [15:0] s12;
    logic [15:0] s13;
  } osc_cfg_t;

  typedef struct {
    logic [16:0] prob;
    logic        zero_e;
  } prob_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [23:0] in_energy_mev = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [16:0] out_probability;
  logic        out_zero_energy;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = nsp_pkg::CFG_BASELINE;
  logic [31:0] cfg_data = '0;

  osc_cfg_t    osc;
  logic [23:0] energy_queue[$];
  prob_beat_t  prob_expected[$];
  int          errors = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          zero_beats = 0;
  int          cfg_writes = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          rx_mode = 0;
  int          rx_count = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;

  always #5 clk = ~clk;

  neutrino_survival_probability_core dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_energy_mev,
    .out_valid, .out_ready, .out_probability, .out_zero_energy,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // sin^2 of 1.267*dm*L/E for a splitting of magnitude mag, Q1.16
  function automatic logic [16:0] sin2_osc(logic [32:0] mag, logic [19:0] len,
                                           logic [23:0] e);
    logic [127:0] prod;
    logic [63:0]  phase, frac, ang, ux, uy, den, num;
    longint       x, y, z, dx, dy;
    prod = 128'(mag) * 128'(nsp_pkg::PHASE_CONST) * 128'(len);
    phase = 64'(prod >> (52 - PFB));
    frac = (phase / 64'(e)) & ((64'd1 << PFB) - 64'd1);
    ang = (frac << 31) >> PFB;
    // fold into the first quarter turn
    if (ang > (64'd1 << 30)) ang = (64'd1 << 31) - ang;
    x = longint'(1) << 30;
    y = 0;
    z = longint'(ang);
    for (int i = 0; i < NSTAGE && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(nsp_pkg::ATAN_TURNS[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(nsp_pkg::ATAN_TURNS[i]);
      end
    end
    ux = 64'(x < 0 ? -x : x) >> 8;
    uy = 64'(y < 0 ? -y : y) >> 8;
    den = ux * ux + uy * uy;
    if (den == 0) return '0;
    num = (uy * uy) << 16;
    return 17'(num / den);
  endfunction

  function automatic prob_beat_t survival_prob(logic [23:0] e, osc_cfg_t c);
    prob_beat_t r;
    longint     d31, d32, p;
    logic [63:0] s12, c12, s13, c13, s21v, s31v, s32v, a1, a2, b1, b2, b3;
    if (e == 0) begin
      r.prob = nsp_pkg::ONE_Q16;
      r.zero_e = 1'b1;
      return r;
    end
    d31 = longint'($signed(c.dm31));
    d32 = d31 - longint'(c.dm21);
    if (d31 > 0) s13 = 64'(nsp_pkg::S13_NORMAL);
    else if (d31 < 0) s13 = 64'(nsp_pkg::S13_INVERTED);
    else s13 = 64'(c.s13);
    c13 = 64'(nsp_pkg::ONE_Q16) - s13;
    s12 = 64'(c.s12);
    c12 = 64'(nsp_pkg::ONE_Q16) - s12;
    s21v = 64'(sin2_osc(33'(c.dm21), c.baseline, e));
    s31v = 64'(sin2_osc(33'(d31 < 0 ? -d31 : d31), c.baseline, e));
    s32v = 64'(sin2_osc(33'(d32 < 0 ? -d32 : d32), c.baseline, e));
    a1 = (64'd4 * s13 * c13) >> 16;
    a2 = (c12 * s31v + s12 * s32v) >> 16;
    b1 = (c13 * c13) >> 16;
    b2 = (64'd4 * s12 * c12) >> 16;
    b3 = (b1 * b2) >> 16;
    p = (longint'(1) << 32) - longint'(a1 * a2) - longint'(b3 * s21v);
    if (p < 0) p = 0;
    p = p >>> 16;
    if (p > longint'(nsp_pkg::ONE_Q16)) p = longint'(nsp_pkg::ONE_Q16);
    r.prob = 17'(p);
    r.zero_e = 1'b0;
    return r;
  endfunction

  // Energy driver: bursts of random length, random gaps, some gap-free stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        prob_expected.push_back(survival_prob(in_energy_mev, osc));
        beats_in <= beats_in + 1;
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (energy_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_energy_mev <= energy_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Probability monitor and the receiver's ready pattern.
  always @(posedge clk) begin
    prob_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_out <= beats_out + 1;
      if (out_zero_energy) zero_beats <= zero_beats + 1;
      if (prob_expected.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected beat prob=%0d zero=%0b", $time,
                 out_probability, out_zero_energy);
      end else begin
        want = prob_expected.pop_front();
        if (out_probability !== want.prob) begin
          errors = errors + 1;
          $display("%0t: probability expected %0d actual %0d", $time,
                   want.prob, out_probability);
        end
        if (out_zero_energy !== want.zero_e) begin
          errors = errors + 1;
          $display("%0t: zero_energy expected %0b actual %0b", $time,
                   want.zero_e, out_zero_energy);
        end
      end
    end
    rx_count <= rx_count + 1;
    // one long hold-off so the pipeline backs up into the input
    if (!long_hold_done && beats_in >= 400) begin
      long_hold_done <= 1'b1;
      hold_left <= 500;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (rx_count % 23) < 15;
      endcase
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      nsp_pkg::CFG_BASELINE: osc.baseline = val[19:0];
      nsp_pkg::CFG_DM21:     osc.dm21 = val[30:0];
      nsp_pkg::CFG_DM31:     osc.dm31 = val;
      nsp_pkg::CFG_S12:      osc.s12 = val[15:0];
      nsp_pkg::CFG_S13:      osc.s13 = val[15:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (energy_queue.size() > 0 || in_valid || prob_expected.size() > 0);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_energy();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return 24'($urandom_range(1, 4096));          // huge phases
      3, 4, 5, 6: return 24'($urandom_range(65536, 655360)); // 1..10 MeV
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic load_items(int n);
    repeat (n) energy_queue.push_back(rand_energy());
  endtask

  initial begin
    osc = '{nsp_pkg::RST_BASELINE, nsp_pkg::RST_DM21, nsp_pkg::RST_DM31,
            nsp_pkg::RST_S12, nsp_pkg::RST_S13};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, single bits, zero energy, reactor energies
    energy_queue = '{24'd0, 24'd1, 24'hFFFFFF, 24'h800000, 24'h7FFFFF,
                     24'd2, 24'd65536, 24'd131072, 24'd196608, 24'd262144,
                     24'd0, 24'h555555, 24'hAAAAAA, 24'd655360, 24'd3};
    rx_mode = 0;
    wait_idle();

    // normal ordering with the usual splittings
    reg_write(nsp_pkg::CFG_DM31, 32'd172000000);
    rx_mode = 1;
    load_items(200);
    wait_idle();

    // inverted ordering; long hold-off lands in this phase
    reg_write(nsp_pkg::CFG_DM31, -32'sd168000000);
    rx_mode = 3;
    load_items(400);
    wait_idle();

    // zero dm31 uses the sin2_theta13 register; extremes of the mixings
    reg_write(nsp_pkg::CFG_DM31, 32'd0);
    reg_write(nsp_pkg::CFG_S13, 32'd65535);
    reg_write(nsp_pkg::CFG_S12, 32'd0);
    rx_mode = 2;
    load_items(150);
    wait_idle();

    reg_write(nsp_pkg::CFG_S13, 32'd0);
    reg_write(nsp_pkg::CFG_S12, 32'd65535);
    reg_write(nsp_pkg::CFG_BASELINE, 32'hFFFFF);
    reg_write(nsp_pkg::CFG_DM21, 32'h7FFFFFFF);
    rx_mode = 1;
    load_items(150);
    wait_idle();

    // zero baseline, extreme splittings, ignored indexes carrying junk
    reg_write(nsp_pkg::CFG_BASELINE, 32'd0);
    reg_write(nsp_pkg::CFG_DM31, 32'h80000000);
    reg_write(CFG_IDX_SPARE_LO, 32'hFFFFFFFF);
    reg_write(CFG_IDX_SPARE_HI, 32'hFFFFFFFF);
    rx_mode = 0;
    load_items(80);
    wait_idle();

    reg_write(nsp_pkg::CFG_BASELINE, 32'd52500);
    reg_write(nsp_pkg::CFG_DM21, 32'd0);
    reg_write(nsp_pkg::CFG_DM31, 32'h7FFFFFFF);
    rx_mode = 3;
    load_items(100);
    wait_idle();

    // random settings, with all bits of every register exercised over time
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(nsp_pkg::CFG_BASELINE, $urandom);
      reg_write(nsp_pkg::CFG_DM21, ($urandom_range(0, 1) != 0) ? $urandom
                                                      : $urandom_range(0, 16000000));
      reg_write(nsp_pkg::CFG_DM31, ($urandom_range(0, 1) != 0) ? $urandom
                                                      : 32'($urandom_range(0, 400000000))
                                                        - 32'd200000000);
      reg_write(nsp_pkg::CFG_S12, $urandom);
      reg_write(nsp_pkg::CFG_S13, $urandom);
      rx_mode = ph % 4;
      load_items(95);
      wait_idle();
    end

    $display("Checked %0d probability beats (%0d zero-energy) over %0d register writes,",
             beats_out, zero_beats, cfg_writes);
    $display("both orderings, zero dm31, extreme baselines/mixings and back-pressure.");
    if (errors == 0 && prob_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout");
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/nsp_pkg.sv
rtl/nsp_div_cell.sv
rtl/nsp_cordic_cell.sv
rtl/nsp_ratio_cell.sv
rtl/nsp_lane.sv
rtl/neutrino_survival_probability_core.sv
sim/testbench.sv
